### design/pcs_pkg.sv
// Shared types, register codes and constants of the PLL calibration sequencer.
package pcs_pkg;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TX_POLL,
        PH_TX_WAIT,
        PH_TX_CHECK,
        PH_CAL7_POLL,
        PH_CAL7_WAIT,
        PH_CAL4_POLL,
        PH_CAL4_WAIT,
        PH_CAL_CHECK,
        PH_CAL_FINAL,
        PH_TAIL_IF
    } phase_t;

    // Input item kinds.
    typedef enum logic [1:0] {
        CMD_TX_SETUP,
        CMD_CALIBRATE,
        CMD_REPLY,
        CMD_TICK
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TX_ANALOG,
        CFG_PA_LEVEL,
        CFG_MAX_ATTEMPTS,
        CFG_TIMEOUT_MS
    } cfg_index_t;

    // Radio register addresses.
    localparam logic [6:0] ADDR_MAIN      = 7'h00;
    localparam logic [6:0] ADDR_INTERFACE = 7'h01;
    localparam logic [6:0] ADDR_LOCK      = 7'h15;
    localparam logic [6:0] ADDR_ANALOG    = 7'h17;
    localparam logic [6:0] ADDR_CALIBRATE = 7'h1B;
    localparam logic [6:0] ADDR_PA_CTRL   = 7'h1C;
    localparam logic [6:0] ADDR_STATUS    = 7'h40;

    // Register values and status bits.
    localparam logic [7:0] CAL_START_CMD  = 8'hB4;
    localparam logic [7:0] MAIN_TX_MODE   = 8'hC1;
    localparam logic [7:0] LOCK_PIN_MODE  = 8'h20;
    localparam logic [7:0] BIT_CAL_DONE   = 8'h80;
    localparam logic [7:0] BIT_PLL_LOCK   = 8'h10;

    // Configuration reset values.
    localparam logic [7:0] RST_TX_ANALOG    = 8'd71;
    localparam logic [7:0] RST_PA_LEVEL     = 8'd240;
    localparam logic [3:0] RST_MAX_ATTEMPTS = 4'd4;
    localparam logic [7:0] RST_TIMEOUT_MS   = 8'd30;

    // Results per input item.
    localparam int MAX_RES = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int CNT_W = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] tx_analog;
        logic [7:0] pa_level;
        logic [3:0] max_attempts;
        logic [7:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic       is_write;
        logic [6:0] reg_addr;
        logic [7:0] write_data;
        logic       finished;
        logic       locked;
    } res_t;

    // All results caused by one input item, in issue order from index 0.
    typedef struct packed {
        res_t [MAX_RES-1:0] res;
        logic [CNT_W-1:0]   count;
    } batch_t;

    function automatic res_t mk_write(logic [6:0] addr, logic [7:0] data);
        res_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_addr = addr;
        r.write_data = data;
        return r;
    endfunction

    function automatic res_t mk_read(logic [6:0] addr);
        res_t r;
        r = '0;
        r.reg_addr = addr;
        return r;
    endfunction

    function automatic res_t mk_report(logic lock);
        res_t r;
        r = '0;
        r.finished = 1'b1;
        r.locked = lock;
        return r;
    endfunction

endpackage

### design/pcs_step.sv
// Sequencer state and the single-pass logic that turns one input item into its results.
module pcs_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    input  pcs_pkg::cmd_t  item_cmd,
    input  logic [7:0]     item_data,
    input  pcs_pkg::cfg_t  cfg,
    input  logic           fire,
    output pcs_pkg::batch_t batch
);
    import pcs_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] attempts_reg, attempts_next;
    logic [7:0] ticks_reg, ticks_next;
    logic       lock_reg, lock_next;
    logic       in_tx_reg, in_tx_next;

    always_comb begin
        logic                 f_begin;
        logic                 f_start;
        logic                 f_end;
        logic                 f_tail;
        logic                 data_lock;
        logic [3:0]           att_dec;
        logic [CNT_W-1:0]     k;
        res_t [MAX_RES-1:0]   res;

        phase_next = phase_reg;
        attempts_next = attempts_reg;
        ticks_next = ticks_reg;
        lock_next = lock_reg;
        in_tx_next = in_tx_reg;
        f_begin = 1'b0;
        f_start = 1'b0;
        f_end = 1'b0;
        f_tail = 1'b0;
        data_lock = (item_data & BIT_PLL_LOCK) != 8'd0;
        att_dec = attempts_reg - 4'd1;
        k = '0;
        res = '0;

        unique case (item_cmd)
            CMD_TX_SETUP: begin
                if (phase_reg == PH_IDLE) begin
                    in_tx_next = 1'b1;
                    res[0] = mk_write(ADDR_PA_CTRL, 8'd0);
                    res[1] = mk_write(ADDR_ANALOG, cfg.tx_analog);
                    res[2] = mk_write(ADDR_MAIN, MAIN_TX_MODE);
                    res[3] = mk_read(ADDR_STATUS);
                    k = CNT_W'(4);
                    ticks_next = cfg.timeout_ms;
                    phase_next = PH_TX_POLL;
                end
            end
            CMD_CALIBRATE: begin
                if (phase_reg == PH_IDLE) begin
                    in_tx_next = 1'b0;
                    f_begin = 1'b1;
                end
            end
            CMD_TICK: begin
                // A tick only counts while a poll is waiting between reads.
                if (phase_reg == PH_TX_WAIT || phase_reg == PH_CAL7_WAIT ||
                    phase_reg == PH_CAL4_WAIT) begin
                    ticks_next = ticks_reg - 8'd1;
                    res[0] = mk_read(ADDR_STATUS);
                    k = CNT_W'(1);
                    if (phase_reg == PH_TX_WAIT) begin
                        phase_next = PH_TX_POLL;
                    end else if (phase_reg == PH_CAL7_WAIT) begin
                        phase_next = PH_CAL7_POLL;
                    end else begin
                        phase_next = PH_CAL4_POLL;
                    end
                end
            end
            CMD_REPLY: begin
                unique case (phase_reg)
                    PH_TX_POLL: begin
                        if (data_lock || ticks_reg == 8'd0) begin
                            res[0] = mk_read(ADDR_STATUS);
                            k = CNT_W'(1);
                            phase_next = PH_TX_CHECK;
                        end else begin
                            phase_next = PH_TX_WAIT;
                        end
                    end
                    PH_TX_CHECK: begin
                        if (data_lock) begin
                            lock_next = 1'b1;
                            f_tail = 1'b1;
                        end else begin
                            f_begin = 1'b1;
                        end
                    end
                    PH_CAL7_POLL: begin
                        if ((item_data & BIT_CAL_DONE) != 8'd0 || ticks_reg == 8'd0) begin
                            res[0] = mk_read(ADDR_STATUS);
                            k = CNT_W'(1);
                            ticks_next = cfg.timeout_ms;
                            phase_next = PH_CAL4_POLL;
                        end else begin
                            phase_next = PH_CAL7_WAIT;
                        end
                    end
                    PH_CAL4_POLL: begin
                        if (data_lock || ticks_reg == 8'd0) begin
                            res[0] = mk_read(ADDR_STATUS);
                            k = CNT_W'(1);
                            phase_next = PH_CAL_CHECK;
                        end else begin
                            phase_next = PH_CAL4_WAIT;
                        end
                    end
                    PH_CAL_CHECK: begin
                        if (data_lock) begin
                            f_end = 1'b1;
                        end else begin
                            attempts_next = att_dec;
                            if (att_dec != 4'd0) begin
                                f_start = 1'b1;
                            end else begin
                                f_end = 1'b1;
                            end
                        end
                    end
                    PH_CAL_FINAL: begin
                        if (in_tx_reg) begin
                            lock_next = data_lock;
                            f_tail = 1'b1;
                        end else begin
                            res[0] = mk_report(data_lock);
                            k = CNT_W'(1);
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_TAIL_IF: begin
                        // Read-modify-write of the interface register clears the lock bit.
                        res[0] = mk_write(ADDR_INTERFACE, item_data & ~BIT_PLL_LOCK);
                        res[1] = mk_write(ADDR_LOCK, LOCK_PIN_MODE);
                        res[2] = mk_report(lock_reg);
                        k = CNT_W'(3);
                        phase_next = PH_IDLE;
                        in_tx_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        // Shared sequence tails, appended in the order in which they are issued.
        if (f_begin) begin
            res[k[RES_IDX_W-1:0]] = mk_write(ADDR_PA_CTRL, 8'd0);
            k = k + CNT_W'(1);
            attempts_next = cfg.max_attempts;
            if (cfg.max_attempts == 4'd0) begin
                f_end = 1'b1;
            end else begin
                f_start = 1'b1;
            end
        end
        if (f_start) begin
            res[k[RES_IDX_W-1:0]] = mk_write(ADDR_CALIBRATE, CAL_START_CMD);
            k = k + CNT_W'(1);
            res[k[RES_IDX_W-1:0]] = mk_read(ADDR_STATUS);
            k = k + CNT_W'(1);
            ticks_next = cfg.timeout_ms;
            phase_next = PH_CAL7_POLL;
        end
        if (f_end) begin
            res[k[RES_IDX_W-1:0]] = mk_write(ADDR_PA_CTRL, cfg.pa_level);
            k = k + CNT_W'(1);
            res[k[RES_IDX_W-1:0]] = mk_read(ADDR_STATUS);
            k = k + CNT_W'(1);
            phase_next = PH_CAL_FINAL;
        end
        if (f_tail) begin
            res[k[RES_IDX_W-1:0]] = mk_write(ADDR_PA_CTRL, cfg.pa_level);
            k = k + CNT_W'(1);
            res[k[RES_IDX_W-1:0]] = mk_read(ADDR_INTERFACE);
            k = k + CNT_W'(1);
            phase_next = PH_TAIL_IF;
        end

        batch.res = res;
        batch.count = item_valid ? k : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            attempts_reg <= '0;
            ticks_reg <= '0;
            lock_reg <= 1'b0;
            in_tx_reg <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            attempts_reg <= attempts_next;
            ticks_reg <= ticks_next;
            lock_reg <= lock_next;
            in_tx_reg <= in_tx_next;
        end
    end

endmodule

### design/pcs_outbuf.sv
// Result register bank that hands out one item's results one transfer at a time.
module pcs_outbuf (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  pcs_pkg::batch_t batch,
    output logic            buf_free,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);
    import pcs_pkg::*;

    res_t [MAX_RES-1:0] buf_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [RES_IDX_W-1:0] ptr_reg;
    res_t               cur;

    assign cur = buf_reg[ptr_reg];
    assign m_tvalid = rem_reg != '0;
    assign m_tlast = rem_reg == CNT_W'(1);
    assign m_tdata = {cur.locked, cur.write_data, cur.reg_addr};
    assign m_tuser = {cur.finished, cur.is_write};
    // Free when empty, or once the last pending result leaves in this cycle.
    assign buf_free = (rem_reg == '0) || (m_tlast && m_tready);

    always_ff @(posedge aclk) begin
        if (load && batch.count != '0) begin
            buf_reg <= batch.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            ptr_reg <= '0;
        end else if (load && batch.count != '0) begin
            rem_reg <= batch.count;
            ptr_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            rem_reg <= rem_reg - CNT_W'(1);
            ptr_reg <= ptr_reg + RES_IDX_W'(1);
        end
    end

endmodule

### design/rf_pll_calibration_sequencer.sv
// Top level of the radio PLL bring-up and calibration sequencer.
// Each input transfer (start command, status read reply or millisecond tick) is held
// in an input register, processed in one pass that updates the sequencer state and
// produces zero to four results (register accesses and, where a sequence ends, a
// completion report last), and those results leave through a small result bank at
// one transfer per cycle while m_tready is high, the last one marked by m_tlast. An
// item with no results bypasses the result bank. A new item is taken while the
// previous one's last result is still waiting. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must do so only while the sequencer is
// idle, as the block itself does not enforce it.
module rf_pll_calibration_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // read_data
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // reg_addr[6:0], write_data[14:7], locked[15]
    output logic [1:0]  m_tuser,   // is_write[0], finished[1]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import pcs_pkg::*;

    logic       in_valid_reg;
    cmd_t       in_cmd_reg;
    logic [7:0] in_data_reg;
    cfg_t       cfg_reg;
    batch_t     batch;
    logic       buf_free;
    logic       fire;

    // An item with no results never needs the result bank.
    assign fire = in_valid_reg && (buf_free || batch.count == '0);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg <= cmd_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tx_analog <= RST_TX_ANALOG;
            cfg_reg.pa_level <= RST_PA_LEVEL;
            cfg_reg.max_attempts <= RST_MAX_ATTEMPTS;
            cfg_reg.timeout_ms <= RST_TIMEOUT_MS;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TX_ANALOG:    cfg_reg.tx_analog <= cfg_data;
                CFG_PA_LEVEL:     cfg_reg.pa_level <= cfg_data;
                CFG_MAX_ATTEMPTS: cfg_reg.max_attempts <= cfg_data[3:0];
                CFG_TIMEOUT_MS:   cfg_reg.timeout_ms <= cfg_data;
            endcase
        end
    end

    pcs_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_cmd   (in_cmd_reg),
        .item_data  (in_data_reg),
        .cfg        (cfg_reg),
        .fire       (fire),
        .batch      (batch)
    );

    pcs_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .batch    (batch),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/pcs_checker.sv
// Port-level checks of the sequencer, bound to the top level.
module pcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
        $stable(m_tlast))
        else $error("stalled result changed");

    // The completion report always closes its run.
    a_report_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("completion report not last of run");

    // The completion report carries no access.
    a_report_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[14:0] == 15'd0)
        else $error("completion report carries an access");

    // Lock is only reported on the completion report.
    a_lock_on_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[15] |-> m_tuser[1])
        else $error("lock flag on an access result");

    // Reset empties the result side.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rf_pll_calibration_sequencer pcs_checker u_pcs_checker (.*);

### sim/tb.sv
// Self-checking testbench for the PLL calibration sequencer: directed runs, then random sessions.
module tb;
    import pcs_pkg::*;

    localparam int unsigned LIMIT = 400000;
    localparam int SETTLE = 20;
    localparam int IDLE_PCT = 27;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // read_data
    logic [1:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // reg_addr[6:0], write_data[14:7], locked[15]
    logic [1:0]  m_tuser;        // is_write[0], finished[1]
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    rf_pll_calibration_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    typedef struct packed {
        res_t acc;
        logic last;
    } access_exp_t;

    access_exp_t awaited_q[$];
    access_exp_t batch_q[$];

    // Our own copy of the sequencer state and its registers.
    phase_t     seq_ph = PH_IDLE;
    logic [3:0] tries_left = '0;
    logic [7:0] ticks_m = '0;
    logic       lock_seen = 1'b0;
    logic       tx_run = 1'b0;
    cfg_t       regs = '{RST_TX_ANALOG, RST_PA_LEVEL, RST_MAX_ATTEMPTS, RST_TIMEOUT_MS};

    bit          calm = 1'b0;
    bit          failed = 1'b0;
    bit          sent_taken;
    int unsigned cycle_count = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("rf_pll_calibration_sequencer: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void add_access(logic w, logic [6:0] a, logic [7:0] d, logic fin,
                                       logic lk);
        access_exp_t e;
        e.acc.is_write   = w;
        e.acc.reg_addr   = a;
        e.acc.write_data = d;
        e.acc.finished   = fin;
        e.acc.locked     = lk;
        e.last           = 1'b0;
        batch_q.push_back(e);
    endfunction

    function automatic void start_try();
        add_access(1'b1, ADDR_CALIBRATE, CAL_START_CMD, 1'b0, 1'b0);
        add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
        ticks_m = regs.timeout_ms;
        seq_ph = PH_CAL7_POLL;
    endfunction

    function automatic void end_cal();
        add_access(1'b1, ADDR_PA_CTRL, regs.pa_level, 1'b0, 1'b0);
        add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
        seq_ph = PH_CAL_FINAL;
    endfunction

    function automatic void begin_cal();
        add_access(1'b1, ADDR_PA_CTRL, 8'h00, 1'b0, 1'b0);
        tries_left = regs.max_attempts;
        if (tries_left == 4'd0)
            end_cal();
        else
            start_try();
    endfunction

    function automatic void enter_tail();
        add_access(1'b1, ADDR_PA_CTRL, regs.pa_level, 1'b0, 1'b0);
        add_access(1'b0, ADDR_INTERFACE, 8'h00, 1'b0, 1'b0);
        seq_ph = PH_TAIL_IF;
    endfunction

    // A poll ends on the wanted status bit or when its ticks have run out.
    function automatic bit poll_done(logic [7:0] d, logic [7:0] mask, phase_t wait_ph);
        if ((d & mask) != 8'h00 || ticks_m == 8'd0)
            return 1'b1;
        seq_ph = wait_ph;
        return 1'b0;
    endfunction

    // Advances our copy of the sequencer by one input transfer and queues the accesses it
    // causes; returns zero when the sequencer ignores the item.
    function automatic bit predict_accesses(cmd_t c, logic [7:0] d);
        bit acted;
        acted = 1'b1;
        batch_q.delete();
        case (c)
            CMD_TX_SETUP, CMD_CALIBRATE: begin
                if (seq_ph != PH_IDLE) begin
                    acted = 1'b0;
                end else if (c == CMD_TX_SETUP) begin
                    tx_run = 1'b1;
                    add_access(1'b1, ADDR_PA_CTRL, 8'h00, 1'b0, 1'b0);
                    add_access(1'b1, ADDR_ANALOG, regs.tx_analog, 1'b0, 1'b0);
                    add_access(1'b1, ADDR_MAIN, MAIN_TX_MODE, 1'b0, 1'b0);
                    add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
                    ticks_m = regs.timeout_ms;
                    seq_ph = PH_TX_POLL;
                end else begin
                    tx_run = 1'b0;
                    begin_cal();
                end
            end
            CMD_TICK: begin
                if (seq_ph inside {PH_TX_WAIT, PH_CAL7_WAIT, PH_CAL4_WAIT}) begin
                    ticks_m = ticks_m - 8'd1;
                    add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
                    seq_ph = phase_t'(seq_ph - 1);
                end else begin
                    acted = 1'b0;
                end
            end
            default: begin
                case (seq_ph)
                    PH_TX_POLL: begin
                        if (poll_done(d, BIT_PLL_LOCK, PH_TX_WAIT)) begin
                            add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
                            seq_ph = PH_TX_CHECK;
                        end
                    end
                    PH_TX_CHECK: begin
                        if ((d & BIT_PLL_LOCK) != 8'h00) begin
                            lock_seen = 1'b1;
                            enter_tail();
                        end else begin
                            begin_cal();
                        end
                    end
                    PH_CAL7_POLL: begin
                        if (poll_done(d, BIT_CAL_DONE, PH_CAL7_WAIT)) begin
                            add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
                            ticks_m = regs.timeout_ms;
                            seq_ph = PH_CAL4_POLL;
                        end
                    end
                    PH_CAL4_POLL: begin
                        if (poll_done(d, BIT_PLL_LOCK, PH_CAL4_WAIT)) begin
                            add_access(1'b0, ADDR_STATUS, 8'h00, 1'b0, 1'b0);
                            seq_ph = PH_CAL_CHECK;
                        end
                    end
                    PH_CAL_CHECK: begin
                        if ((d & BIT_PLL_LOCK) != 8'h00) begin
                            end_cal();
                        end else begin
                            tries_left = tries_left - 4'd1;
                            if (tries_left != 4'd0)
                                start_try();
                            else
                                end_cal();
                        end
                    end
                    PH_CAL_FINAL: begin
                        if (tx_run) begin
                            lock_seen = d[4];
                            enter_tail();
                        end else begin
                            add_access(1'b0, 7'h00, 8'h00, 1'b1, d[4]);
                            seq_ph = PH_IDLE;
                        end
                    end
                    PH_TAIL_IF: begin
                        add_access(1'b1, ADDR_INTERFACE, d & ~BIT_PLL_LOCK, 1'b0, 1'b0);
                        add_access(1'b1, ADDR_LOCK, LOCK_PIN_MODE, 1'b0, 1'b0);
                        add_access(1'b0, 7'h00, 8'h00, 1'b1, lock_seen);
                        seq_ph = PH_IDLE;
                        tx_run = 1'b0;
                    end
                    default: acted = 1'b0;
                endcase
            end
        endcase
        if (batch_q.size() > 0)
            batch_q[batch_q.size() - 1].last = 1'b1;
        foreach (batch_q[i])
            awaited_q.push_back(batch_q[i]);
        return acted;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        access_exp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_q.size() == 0) begin
                $error("result with nothing expected: tdata %0h tuser %0h tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                failed = 1'b1;
            end else begin
                want = awaited_q.pop_front();
                check_field("is_write", want.acc.is_write, m_tuser[0]);
                check_field("reg_addr", want.acc.reg_addr, m_tdata[6:0]);
                check_field("write_data", want.acc.write_data, m_tdata[14:7]);
                check_field("finished", want.acc.finished, m_tuser[1]);
                check_field("locked", want.acc.locked, m_tdata[15]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    // Offers one item and returns at the edge where the transfer takes place. tvalid stays
    // high afterwards so that a following item can go out without a gap.
    task automatic send_item(input cmd_t c, input logic [7:0] d);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_taken = predict_accesses(c, d);
    endtask

    // Holds the sender back until every expected result has arrived and the block has settled.
    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_TX_ANALOG:    regs.tx_analog = v;
            CFG_PA_LEVEL:     regs.pa_level = v;
            CFG_MAX_ATTEMPTS: regs.max_attempts = v[3:0];
            default:          regs.timeout_ms = v;
        endcase
    endtask

    // Plays the radio: a start when idle, a tick while waiting between reads, a status
    // reply otherwise, with an occasional stray item when noisy.
    task automatic answer_radio(input int lock_pct, input bit noisy);
        logic [7:0] d;
        d = 8'($urandom_range(255));
        d[4] = ($urandom_range(99) < lock_pct);
        d[7] = ($urandom_range(99) < lock_pct);
        if (noisy && $urandom_range(99) < 12) begin
            send_item(cmd_t'($urandom_range(3)), d);
        end else begin
            case (seq_ph)
                PH_IDLE: send_item(($urandom_range(1) != 0) ? CMD_TX_SETUP : CMD_CALIBRATE, d);
                PH_TX_WAIT, PH_CAL7_WAIT, PH_CAL4_WAIT: send_item(CMD_TICK, d);
                default: send_item(CMD_REPLY, d);
            endcase
        end
    endtask

    task automatic test_tx_locks_first();
        send_item(CMD_TX_SETUP, 8'hFF);
        send_item(CMD_REPLY, 8'h10);
        send_item(CMD_REPLY, 8'hFF);
        send_item(CMD_REPLY, 8'hFF);
        pause_sender();
    endtask

    // Stray replies, ticks and starts around a standalone calibration that fails once.
    task automatic test_standalone_and_strays();
        send_item(CMD_REPLY, 8'h5A);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_CALIBRATE, 8'h00);
        send_item(CMD_TX_SETUP, 8'h00);
        send_item(CMD_CALIBRATE, 8'hFF);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_REPLY, 8'h80);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_REPLY, 8'h80);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_TICK, 8'h00);
        send_item(CMD_REPLY, 8'h10);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_REPLY, 8'h80);
        send_item(CMD_REPLY, 8'h10);
        send_item(CMD_REPLY, 8'h10);
        send_item(CMD_REPLY, 8'hEF);
        pause_sender();
    endtask

    // No calibration attempts and no tick allowance: every poll ends on its first read.
    task automatic test_zero_settings();
        write_reg(CFG_MAX_ATTEMPTS, 8'h00);
        write_reg(CFG_TIMEOUT_MS, 8'h00);
        send_item(CMD_TX_SETUP, 8'h00);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_REPLY, 8'h00);
        send_item(CMD_REPLY, 8'h10);
        pause_sender();
    endtask

    task automatic test_random_session(input logic [7:0] tx, input logic [7:0] pa,
                                       input logic [3:0] att, input logic [7:0] tmo,
                                       input int lock_pct, input int count);
        int done;
        write_reg(CFG_TX_ANALOG, tx);
        write_reg(CFG_PA_LEVEL, pa);
        write_reg(CFG_MAX_ATTEMPTS, {4'h0, att});
        write_reg(CFG_TIMEOUT_MS, tmo);
        done = 0;
        while (done < count) begin
            answer_radio(lock_pct, 1'b1);
            if (sent_taken)
                done++;
            if ($urandom_range(99) < 2)
                pause_sender();
        end
        // Bring the sequence back to idle before anything is reconfigured.
        while (seq_ph != PH_IDLE)
            answer_radio(lock_pct, 1'b0);
        pause_sender();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_tx_locks_first();
        test_standalone_and_strays();
        test_zero_settings();
        test_random_session(8'h00, 8'h00, 4'd1, 8'd1, 15, 40);
        test_random_session(8'hFF, 8'hFF, 4'd15, 8'd255, 85, 40);
        calm = 1'b1;
        test_random_session(8'($urandom_range(255)), 8'($urandom_range(255)),
                            4'($urandom_range(15)), 8'($urandom_range(4)), 50, 40);
        calm = 1'b0;
        test_random_session(8'($urandom_range(255)), 8'($urandom_range(255)),
                            4'($urandom_range(15)), 8'($urandom_range(4)), 30, 40);
        test_random_session(8'($urandom_range(255)), 8'($urandom_range(255)),
                            4'd2, 8'd3, 60, 40);

        if (!failed && awaited_q.size() == 0)
            $display("rf_pll_calibration_sequencer: match");
        else
            $display("rf_pll_calibration_sequencer: mismatch");
        $finish;
    end

endmodule

### rf_pll_calibration_sequencer.f
design/pcs_pkg.sv
design/pcs_step.sv
design/pcs_outbuf.sv
design/rf_pll_calibration_sequencer.sv
design/pcs_checker.sv
sim/tb.sv
